### hdl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// Pearson correlation package
// Types and constants shared by the correlation core and its submodules.
// ----------------------------------------------------------------------------
package pcc_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int CORR_WIDTH   = 16;
   localparam int USED_WIDTH   = 8;
   // The root search runs over 17 bits so that the value 1.0 can be found.
   localparam int ROOT_WIDTH   = 17;
   localparam int RHS_SHIFT    = 30;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_MUL,
      BK_DONE
   } back_state_type;

   typedef enum logic [3:0] {
      ST_N_SXX,
      ST_SX_SX,
      ST_N_SYY,
      ST_SY_SY,
      ST_N_SXY,
      ST_SX_SY,
      ST_VX_VY,
      ST_MAG_SQ,
      ST_TRIAL
   } step_type;

endpackage

### hdl/pcc_front.sv
// ----------------------------------------------------------------------------
// Correlation front end
// Takes sample pairs, accumulates count, sums, squares and cross products,
// and hands the finished set to the queue on the last pair.
// ----------------------------------------------------------------------------
module pcc_front #(
   parameter int MAX_SAMPLES = 128,
   parameter int CW = 8,
   parameter int EW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [15:0]           conf_sample,
   input  logic [15:0]           dist_sample,
   input  logic                  last_sample,
   output logic                  working,
   output logic                  push,
   output logic [EW-1:0]         push_data
);
   import pcc_pkg::*;

   localparam int SW = SAMPLE_WIDTH + CW;
   localparam int QW = 2 * SAMPLE_WIDTH + CW;

   logic                    stage_ff, stage_in;
   logic [SAMPLE_WIDTH-1:0] x_ff, y_ff;
   logic                    last_ff;
   logic [CW-1:0]           n_ff, n_in;
   logic [SW-1:0]           sx_ff, sx_in, sy_ff, sy_in;
   logic [QW-1:0]           sxx_ff, sxx_in, syy_ff, syy_in, sxy_ff, sxy_in;
   logic [31:0]             xx, yy, xy;
   logic [CW-1:0]           n_upd;
   logic [SW-1:0]           sx_upd, sy_upd;
   logic [QW-1:0]           sxx_upd, syy_upd, sxy_upd;
   logic                    room;

   assign xx   = {16'b0, x_ff} * {16'b0, x_ff};
   assign yy   = {16'b0, y_ff} * {16'b0, y_ff};
   assign xy   = {16'b0, x_ff} * {16'b0, y_ff};
   assign room = n_ff < CW'(MAX_SAMPLES);

   always_comb begin
      if (room) begin
         n_upd   = n_ff + CW'(1);
         sx_upd  = sx_ff + SW'(x_ff);
         sy_upd  = sy_ff + SW'(y_ff);
         sxx_upd = sxx_ff + QW'(xx);
         syy_upd = syy_ff + QW'(yy);
         sxy_upd = sxy_ff + QW'(xy);
      end else begin
         n_upd   = n_ff;
         sx_upd  = sx_ff;
         sy_upd  = sy_ff;
         sxx_upd = sxx_ff;
         syy_upd = syy_ff;
         sxy_upd = sxy_ff;
      end
   end

   always_comb begin
      stage_in = accept;
      n_in     = n_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sxx_in   = sxx_ff;
      syy_in   = syy_ff;
      sxy_in   = sxy_ff;
      if (stage_ff) begin
         if (last_ff) begin
            n_in   = '0;
            sx_in  = '0;
            sy_in  = '0;
            sxx_in = '0;
            syy_in = '0;
            sxy_in = '0;
         end else begin
            n_in   = n_upd;
            sx_in  = sx_upd;
            sy_in  = sy_upd;
            sxx_in = sxx_upd;
            syy_in = syy_upd;
            sxy_in = sxy_upd;
         end
      end
   end

   assign working   = stage_ff;
   assign push      = stage_ff && last_ff;
   assign push_data = {n_upd, sx_upd, sy_upd, sxx_upd, syy_upd, sxy_upd};

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         n_ff     <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxx_ff   <= '0;
         syy_ff   <= '0;
         sxy_ff   <= '0;
      end else begin
         stage_ff <= stage_in;
         n_ff     <= n_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sxx_ff   <= sxx_in;
         syy_ff   <= syy_in;
         sxy_ff   <= sxy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= conf_sample;
         y_ff    <= dist_sample;
         last_ff <= last_sample;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(MAX_SAMPLES))
      else $error("pair count beyond its limit");

endmodule

### hdl/pcc_fifo.sv
// ----------------------------------------------------------------------------
// Set queue
// Two-entry queue of finished sample sets between front and back end.
// ----------------------------------------------------------------------------
module pcc_fifo #(
   parameter int EW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [EW-1:0] push_data,
   input  logic          pop,
   output logic [EW-1:0] head,
   output logic          full,
   output logic          empty
);
   import pcc_pkg::*;

   logic [EW-1:0] mem_ff [2];
   logic          wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]    count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("set queue overflow");

endmodule

### hdl/pcc_back.sv
// ----------------------------------------------------------------------------
// Correlation back end
// Forms the variances and covariance with one shift-add multiplier, then
// finds the Q1.15 coefficient by a bit-by-bit root search unless a variance is zero.
// ----------------------------------------------------------------------------
module pcc_back #(
   parameter int CW = 8,
   parameter int EW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  logic [EW-1:0] head,
   output logic          pop,
   output logic          rsp_valid,
   output logic [15:0]   rsp_corr_value,
   output logic          rsp_degenerate,
   output logic [7:0]    rsp_samples_used
);
   import pcc_pkg::*;

   localparam int SW = SAMPLE_WIDTH + CW;
   localparam int QW = 2 * SAMPLE_WIDTH + CW;
   localparam int VW = 2 * SAMPLE_WIDTH + 2 * CW;
   localparam int PW = 2 * VW + 2 * ROOT_WIDTH;

   back_state_type          state_ff, state_in;
   step_type                step_ff, step_in;
   logic [CW-1:0]           n_ff, n_in;
   logic [SW-1:0]           sx_ff, sx_in, sy_ff, sy_in;
   logic [QW-1:0]           sxx_ff, sxx_in, syy_ff, syy_in, sxy_ff, sxy_in;
   logic [VW-1:0]           tmp_ff, tmp_in, vx_ff, vx_in, vy_ff, vy_in;
   logic [VW-1:0]           mag_ff, mag_in;
   logic                    neg_ff, neg_in, degen_ff, degen_in;
   logic [PW-1:0]           pv_ff, pv_in, rr_ff, rr_in;
   logic [PW-1:0]           a_ff, a_in, acc_ff, acc_in;
   logic [VW-1:0]           b_ff, b_in;
   logic [ROOT_WIDTH-1:0]   q_ff, q_in, trial, neg_q;
   logic [4:0]              bit_ff, bit_in;
   logic [2*ROOT_WIDTH-1:0] tsq;
   logic [VW-1:0]           prod_lo;

   assign trial   = q_ff | (ROOT_WIDTH'(1) << bit_ff);
   assign tsq     = {{ROOT_WIDTH{1'b0}}, trial} * {{ROOT_WIDTH{1'b0}}, trial};
   assign prod_lo = acc_ff[VW-1:0];
   assign neg_q   = ~q_ff + ROOT_WIDTH'(1);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      n_in     = n_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sxx_in   = sxx_ff;
      syy_in   = syy_ff;
      sxy_in   = sxy_ff;
      tmp_in   = tmp_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      degen_in = degen_ff;
      pv_in    = pv_ff;
      rr_in    = rr_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      q_in     = q_ff;
      bit_in   = bit_ff;
      pop      = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop = 1'b1;
               {n_in, sx_in, sy_in, sxx_in, syy_in, sxy_in} = head;
               step_in  = ST_N_SXX;
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            acc_in   = '0;
            state_in = BK_MUL;
            unique case (step_ff)
               ST_N_SXX: begin a_in = PW'(sxx_ff); b_in = VW'(n_ff);  end
               ST_SX_SX: begin a_in = PW'(sx_ff);  b_in = VW'(sx_ff); end
               ST_N_SYY: begin a_in = PW'(syy_ff); b_in = VW'(n_ff);  end
               ST_SY_SY: begin a_in = PW'(sy_ff);  b_in = VW'(sy_ff); end
               ST_N_SXY: begin a_in = PW'(sxy_ff); b_in = VW'(n_ff);  end
               ST_SX_SY: begin a_in = PW'(sx_ff);  b_in = VW'(sy_ff); end
               ST_VX_VY: begin a_in = PW'(vx_ff);  b_in = vy_ff;      end
               ST_MAG_SQ: begin a_in = PW'(mag_ff); b_in = mag_ff;    end
               ST_TRIAL: begin a_in = pv_ff;       b_in = VW'(tsq);   end
               default:  begin a_in = '0;          b_in = '0;         end
            endcase
         end
         BK_MUL: begin
            if (b_ff != '0) begin
               if (b_ff[0]) begin
                  acc_in = acc_ff + a_ff;
               end
               a_in = a_ff << 1;
               b_in = b_ff >> 1;
            end else begin
               state_in = BK_LOAD;
               unique case (step_ff)
                  ST_N_SXX: begin tmp_in = prod_lo; step_in = ST_SX_SX; end
                  ST_SX_SX: begin vx_in = tmp_ff - prod_lo; step_in = ST_N_SYY; end
                  ST_N_SYY: begin tmp_in = prod_lo; step_in = ST_SY_SY; end
                  ST_SY_SY: begin vy_in = tmp_ff - prod_lo; step_in = ST_N_SXY; end
                  ST_N_SXY: begin tmp_in = prod_lo; step_in = ST_SX_SY; end
                  ST_SX_SY: begin
                     neg_in   = tmp_ff < prod_lo;
                     mag_in   = (tmp_ff < prod_lo) ? prod_lo - tmp_ff : tmp_ff - prod_lo;
                     degen_in = (vx_ff == '0) || (vy_ff == '0);
                     q_in     = '0;
                     step_in  = ST_VX_VY;
                     if ((vx_ff == '0) || (vy_ff == '0)) begin
                        state_in = BK_DONE;
                     end
                  end
                  ST_VX_VY: begin pv_in = acc_ff; step_in = ST_MAG_SQ; end
                  ST_MAG_SQ: begin
                     rr_in   = acc_ff << RHS_SHIFT;
                     bit_in  = 5'(ROOT_WIDTH - 1);
                     step_in = ST_TRIAL;
                  end
                  ST_TRIAL: begin
                     // Keep the trial bit when the squared root still fits.
                     if (acc_ff <= rr_ff) begin
                        q_in = trial;
                     end
                     if (bit_ff == 5'd0) begin
                        state_in = BK_DONE;
                     end else begin
                        bit_in = bit_ff - 5'd1;
                     end
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_DONE: begin
            state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   assign rsp_valid        = state_ff == BK_DONE;
   assign rsp_degenerate   = degen_ff;
   assign rsp_samples_used = USED_WIDTH'(n_ff);

   always_comb begin
      if (degen_ff) begin
         rsp_corr_value = '0;
      end else if (neg_ff) begin
         rsp_corr_value = neg_q[CORR_WIDTH-1:0];
      end else if (q_ff > ROOT_WIDTH'(32767)) begin
         rsp_corr_value = 16'h7FFF;
      end else begin
         rsp_corr_value = q_ff[CORR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff  <= ST_N_SXX;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      sxx_ff   <= sxx_in;
      syy_ff   <= syy_in;
      sxy_ff   <= sxy_in;
      tmp_ff   <= tmp_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      degen_ff <= degen_in;
      pv_ff    <= pv_in;
      rr_ff    <= rr_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      acc_ff   <= acc_in;
      q_ff     <= q_in;
      bit_ff   <= bit_in;
   end

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_corr_value == '0)
      else $error("degenerate result with nonzero value");

endmodule

### hdl/pearson_correlation_core.sv
// Each pair is registered, then added into the sums. After the last pair the result strobe
// follows eight shift-add products and a 17-step root search with one product per step;
// a zero variance ends after six products. Sets already waiting in the queue go first.
// No pair is taken while one is added or the queue is full; up to two finished sets may wait.
// Reset clears all sums and the queue. The receiver cannot stall: each result lasts one cycle.
// ----------------------------------------------------------------------------
// Pearson correlation core
// Accumulates sample pairs and reports their correlation coefficient in Q1.15.
// ----------------------------------------------------------------------------
module pearson_correlation_core #(
   parameter int MAX_SAMPLES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_conf_sample,
   input  logic [15:0] req_dist_sample,
   input  logic        req_last_sample,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_corr_value,
   output logic        rsp_degenerate,
   output logic [7:0]  rsp_samples_used
);
   import pcc_pkg::*;

   localparam int CW = $clog2(MAX_SAMPLES + 1);
   localparam int EW = CW + 2 * (SAMPLE_WIDTH + CW) + 3 * (2 * SAMPLE_WIDTH + CW);

   logic          accept, working, push, pop, full, empty;
   logic [EW-1:0] push_data, head;
   logic [15:0]   corr;

   assign busy           = working || full;
   assign accept         = start && !busy;
   assign rsp_corr_value = corr;

   pcc_front #(.MAX_SAMPLES(MAX_SAMPLES), .CW(CW), .EW(EW)) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .conf_sample (req_conf_sample),
      .dist_sample (req_dist_sample),
      .last_sample (req_last_sample),
      .working     (working),
      .push        (push),
      .push_data   (push_data)
   );

   pcc_fifo #(.EW(EW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   pcc_back #(.CW(CW), .EW(EW)) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_corr_value   (corr),
      .rsp_degenerate   (rsp_degenerate),
      .rsp_samples_used (rsp_samples_used)
   );

endmodule

### tb/sv/pearson_correlation_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pearson correlation core testbench
// Drives sample pairs with random gaps, predicts each set's coefficient with
// exact wide integer arithmetic and compares every result strobe against it.
// ----------------------------------------------------------------------------

class corr_scoreboard;
   localparam int MAX_PAIRS = 128;

   longint unsigned pair_count, conf_total, dist_total, conf_sq_total, dist_sq_total;
   longint unsigned cross_total;
   logic signed [15:0] exp_corr[$];
   bit                 exp_degen[$];
   logic [7:0]         exp_used[$];
   int                 error_count;

   function new();
      clear_sums();
      error_count = 0;
   endfunction

   function void clear_sums();
      pair_count = 0; conf_total = 0; dist_total = 0;
      conf_sq_total = 0; dist_sq_total = 0; cross_total = 0;
   endfunction

   function int pending();
      return exp_corr.size();
   endfunction

   // Notes an accepted request and, on a last pair, queues the coefficient.
   function void note_pair(logic [15:0] confidence, logic [15:0] distance, bit last);
      longint unsigned n, vx, vy, p, q, mag;
      logic [127:0] var_prod, rhs;
      logic [159:0] lhs;
      int unsigned lo, hi, mid;
      bit neg, degen;
      logic signed [15:0] corr;
      if (pair_count < MAX_PAIRS) begin
         pair_count++;
         conf_total    += confidence;
         dist_total    += distance;
         conf_sq_total += longint'(confidence) * confidence;
         dist_sq_total += longint'(distance) * distance;
         cross_total   += longint'(confidence) * distance;
      end
      if (!last) return;
      n   = pair_count;
      vx  = n * conf_sq_total - conf_total * conf_total;
      vy  = n * dist_sq_total - dist_total * dist_total;
      p   = n * cross_total;
      q   = conf_total * dist_total;
      neg = p < q;
      mag = neg ? q - p : p - q;
      degen = (vx == 0) || (vy == 0);
      corr = 0;
      if (!degen) begin
         var_prod = 128'(vx) * 128'(vy);
         rhs = (128'(mag) * 128'(mag)) << 30;
         lo = 0; hi = 32768;
         // Largest q with q^2 * Vx * Vy <= mag^2 * 2^30.
         while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            lhs = 160'(var_prod) * 160'(mid * mid);
            if (lhs <= 160'(rhs)) lo = mid;
            else hi = mid - 1;
         end
         if (neg) corr = 16'(-int'(lo));
         else corr = (lo > 32767) ? 16'sd32767 : 16'(lo);
      end
      exp_corr.insert(exp_corr.size(), corr);
      exp_degen.insert(exp_degen.size(), degen);
      exp_used.insert(exp_used.size(), n[7:0]);
      clear_sums();
   endfunction

   function void report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endfunction

   function void check_result(logic signed [15:0] corr, logic degen, logic [7:0] used);
      logic signed [15:0] ec;
      if (exp_corr.size() == 0) begin
         report($sformatf("unexpected result corr=%0d", corr));
         return;
      end
      ec = exp_corr.pop_front();
      if (corr !== ec) report($sformatf("corr_value %0d, expected %0d", corr, ec));
      if (degen !== exp_degen[0])
         report($sformatf("degenerate %0b, expected %0b", degen, exp_degen[0]));
      if (used !== exp_used[0])
         report($sformatf("samples_used %0d, expected %0d", used, exp_used[0]));
      void'(exp_degen.pop_front());
      void'(exp_used.pop_front());
   endfunction
endclass

module pearson_correlation_core_tb;
   localparam int IDLE_LIMIT = 20000;

   logic        clock, reset, start;
   logic        busy;
   logic [15:0] req_conf_sample, req_dist_sample;
   logic        req_last_sample;
   logic        rsp_valid;
   logic signed [15:0] rsp_corr_value;
   logic        rsp_degenerate;
   logic [7:0]  rsp_samples_used;

   corr_scoreboard board;
   int idle_cycles;
   bit stim_done;

   pearson_correlation_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_conf_sample(req_conf_sample), .req_dist_sample(req_dist_sample),
      .req_last_sample(req_last_sample), .rsp_valid(rsp_valid),
      .rsp_corr_value(rsp_corr_value), .rsp_degenerate(rsp_degenerate),
      .rsp_samples_used(rsp_samples_used)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial board = new();

   // Requests and results are taken at the edge from values set at the prior one.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (start && !busy)
            board.note_pair(req_conf_sample, req_dist_sample, req_last_sample);
         if (rsp_valid)
            board.check_result(rsp_corr_value, rsp_degenerate, rsp_samples_used);
         if ((start && !busy) || rsp_valid || (stim_done && board.pending() == 0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Start stays high after an accepted request so that the next one can follow
   // with no gap; it is dropped only when an idle gap comes or the stimulus ends.
   task automatic send_pair(logic [15:0] conf, logic [15:0] distance, bit last);
      int gap;
      gap = ($urandom_range(0, 9) < 6) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_conf_sample <= conf;
      req_dist_sample <= distance;
      req_last_sample <= last;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_set(int count, int mode);
      logic [15:0] c, d, base;
      base = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         c = 16'($urandom);
         case (mode)
            0: d = 16'($urandom);
            1: d = c ^ 16'($urandom_range(0, 255));       // strongly positive
            2: d = ~c;                                     // exact negative
            3: d = base;                                   // constant distance
            default: d = c;                                // exact positive
         endcase
         send_pair(c, d, i == count - 1);
      end
   endtask

   initial begin
      int sent, count;
      start = 1'b0; req_conf_sample = '0; req_dist_sample = '0; req_last_sample = 1'b0;
      stim_done = 1'b0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: empty-ish sets, extremes, perfect +/-1, constant, overflow.
      send_pair(16'hFFFF, 16'h0000, 1'b1);
      send_pair(16'h0000, 16'hFFFF, 1'b0);
      send_pair(16'hFFFF, 16'h0000, 1'b1);
      send_pair(16'h0000, 16'h0000, 1'b0);
      send_pair(16'hFFFF, 16'hFFFF, 1'b1);
      send_pair(16'h1234, 16'h5678, 1'b0);
      send_pair(16'h1234, 16'h9ABC, 1'b1);
      send_set(4, 2);
      send_set(4, 4);
      send_set(3, 3);
      send_set(5, 0);
      send_set(140, 0);        // overflow: extra pairs ignored
      send_set(130, 4);
      sent = 0;
      while (sent < 700) begin
         count = ($urandom_range(0, 19) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 12);
         send_set(count, $urandom_range(0, 4));
         sent += count;
      end
      start <= 1'b0;
      stim_done = 1'b1;
      while (board.pending() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

### sim.f
hdl/pcc_pkg.sv
hdl/pcc_front.sv
hdl/pcc_fifo.sv
hdl/pcc_back.sv
hdl/pearson_correlation_core.sv
tb/sv/pearson_correlation_core_tb.sv
